// ----- sv/mnfr_pkg.sv -----
// ----------------------------------------------------------------------------
// mnfr_pkg
// Shared widths, register indexes and control types of the masked,
// normalized row filter.
// ----------------------------------------------------------------------------
package mnfr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TAP_IDX_W  = 4;
    localparam int RADIUS_W   = 3;
    localparam int FRAC_W     = 14;
    localparam int VAL_W      = 40;
    localparam int POS_W      = 12;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 56;
    localparam int M_PAD_W    = M_TDATA_W - VAL_W - POS_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PADDING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd2;

    typedef struct packed {
        logic clear;
        logic add;
    } mac_ctl_t;

endpackage

// ----- sv/mnfr_ram.sv -----
// ----------------------------------------------------------------------------
// mnfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mnfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/mnfr_mac.sv -----
// ----------------------------------------------------------------------------
// mnfr_mac
// Shared multiply-accumulate: accumulates tap * sample and the sum of the
// taps that took part.
// ----------------------------------------------------------------------------
module mnfr_mac #(
    parameter int ACC_W = 36,
    parameter int WS_W  = 20
) (
    input  logic                               aclk,
    input  mnfr_pkg::mac_ctl_t                 ctl,
    input  logic signed [mnfr_pkg::SAMPLE_W-1:0] tap,
    input  logic signed [mnfr_pkg::SAMPLE_W-1:0] sample,
    output logic signed [ACC_W-1:0]            acc,
    output logic signed [WS_W-1:0]             wsum
);

    logic signed [2*mnfr_pkg::SAMPLE_W-1:0] prod;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [WS_W-1:0]  wsum_reg, wsum_next;

    assign prod = tap * sample;

    always_comb begin
        acc_next  = acc_reg;
        wsum_next = wsum_reg;
        if (ctl.clear) begin
            acc_next  = '0;
            wsum_next = '0;
        end else if (ctl.add) begin
            acc_next  = acc_reg
                      + {{(ACC_W-2*mnfr_pkg::SAMPLE_W){prod[2*mnfr_pkg::SAMPLE_W-1]}}, prod};
            wsum_next = wsum_reg
                      + {{(WS_W-mnfr_pkg::SAMPLE_W){tap[mnfr_pkg::SAMPLE_W-1]}}, tap};
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        wsum_reg <= wsum_next;
    end

    assign acc  = acc_reg;
    assign wsum = wsum_reg;

endmodule

// ----- sv/mnfr_div.sv -----
// ----------------------------------------------------------------------------
// mnfr_div
// Restoring unsigned divider, one quotient bit per cycle, most significant
// bit first. Leaves quotient and remainder for the rounding step.
// ----------------------------------------------------------------------------
module mnfr_div #(
    parameter int NW = 50,
    parameter int DW = 20
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    num_reg, num_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             fits;

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign fits   = (rem_sh >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NW);
            num_next  = num;
            den_next  = den;
            quo_next  = '0;
            rem_next  = '0;
        end else if (busy_reg) begin
            num_next = {num_reg[NW-2:0], 1'b0};
            quo_next = {quo_reg[NW-2:0], fits};
            rem_next = fits ? diff[DW-1:0] : rem_sh[DW-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- sv/masked_normalized_fir_row_core.sv -----
// ----------------------------------------------------------------------------
// masked_normalized_fir_row_core
// Per result: the center is read; at or below padding it gives the padding
// value, else the taps run through the MAC, and normalize mode with a nonzero
// tap sum divides (NW = 50 numerator bits), rounds, saturates; emits when free.
// Throughput: one item at a time; s_tready stays low until its last result.
// Reset (aresetn low, synchronous) clears taps, row position and output valid.
// ----------------------------------------------------------------------------
module masked_normalized_fir_row_core #(
    parameter int MAX_RADIUS = 7,
    parameter int MAX_ROW    = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [mnfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mnfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    // Input items.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0 up: sample[15:0], tap_index[19:16], tap_value[35:20],
    // zero fill [39:36].
    input  logic [mnfr_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: action (0 row sample, 1 tap load).
    input  logic                              s_tuser,
    // s_tlast: row_end.
    input  logic                              s_tlast,

    // Result items.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0 up: value[39:0], position[51:40], zero fill [55:52].
    output logic [mnfr_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: is_padding.
    output logic                              m_tuser,
    // m_tlast: last_of_row.
    output logic                              m_tlast
);

    localparam int NTAPS  = 2 * MAX_RADIUS + 1;
    localparam int TW     = $clog2(NTAPS);
    localparam int WA     = $clog2(NTAPS);
    localparam int WDEPTH = 1 << WA;
    localparam int CW     = $clog2(MAX_ROW);
    localparam int XW     = CW + 2;
    localparam int ACC_W  = 2 * mnfr_pkg::SAMPLE_W + $clog2(NTAPS);
    localparam int WS_W   = mnfr_pkg::SAMPLE_W + $clog2(NTAPS);
    localparam int NW     = ACC_W + mnfr_pkg::FRAC_W;
    localparam int QW     = NW + 1;
    localparam int SW     = 4;
    localparam int VAL_W  = mnfr_pkg::VAL_W;

    localparam logic [SW-1:0] ST_IDLE  = 4'd0;
    localparam logic [SW-1:0] ST_CEN   = 4'd1;
    localparam logic [SW-1:0] ST_CHK   = 4'd2;
    localparam logic [SW-1:0] ST_MAC   = 4'd3;
    localparam logic [SW-1:0] ST_DRAIN = 4'd4;
    localparam logic [SW-1:0] ST_FIN   = 4'd5;
    localparam logic [SW-1:0] ST_DIV   = 4'd6;
    localparam logic [SW-1:0] ST_RND   = 4'd7;
    localparam logic [SW-1:0] ST_SAT   = 4'd8;
    localparam logic [SW-1:0] ST_EMIT  = 4'd9;

    localparam logic [QW-1:0]    Q_HALF  = QW'(1) << (VAL_W - 1);
    localparam logic [VAL_W-1:0] VAL_MIN = VAL_W'(1) << (VAL_W - 1);
    localparam logic [VAL_W-1:0] VAL_MAX = ~VAL_MIN;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [mnfr_pkg::SAMPLE_W-1:0] pad_reg;
    logic                                 norm_reg;
    logic [mnfr_pkg::RADIUS_W-1:0]        radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_reg    <= '0;
            norm_reg   <= 1'b1;
            radius_reg <= mnfr_pkg::RADIUS_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mnfr_pkg::CFG_PADDING:   pad_reg    <= cfg_wdata[mnfr_pkg::SAMPLE_W-1:0];
                mnfr_pkg::CFG_NORMALIZE: norm_reg   <= cfg_wdata[0];
                mnfr_pkg::CFG_RADIUS:    radius_reg <= cfg_wdata[mnfr_pkg::RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input item fields.
    // ------------------------------------------------------------------
    logic signed [mnfr_pkg::SAMPLE_W-1:0] in_sample;
    logic [mnfr_pkg::TAP_IDX_W-1:0]       in_tap_idx;
    logic signed [mnfr_pkg::SAMPLE_W-1:0] in_tap_val;
    logic                                 in_accept;
    logic                                 tap_idx_ok;

    assign in_sample  = s_tdata[15:0];
    assign in_tap_idx = s_tdata[19:16];
    assign in_tap_val = s_tdata[35:20];
    assign in_accept  = s_tvalid && s_tready;
    assign tap_idx_ok = (32'(in_tap_idx) < NTAPS);

    // ------------------------------------------------------------------
    // Sequencer state.
    // ------------------------------------------------------------------
    logic [SW-1:0]                 state_reg, state_next;
    logic [CW-1:0]                 row_cnt_reg, row_cnt_next;
    logic [CW-1:0]                 p_reg, p_next;
    logic [CW-1:0]                 c_reg, c_next;
    logic [CW-1:0]                 c_end_reg, c_end_next;
    logic [mnfr_pkg::RADIUS_W-1:0] r_reg, r_next;
    logic                          end_reg, end_next;
    logic [3:0]                    k_reg, k_next;
    logic                          rd_live_reg, rd_live_next;
    logic [VAL_W-1:0]              res_value_reg, res_value_next;
    logic                          res_pad_reg, res_pad_next;
    logic                          neg_reg, neg_next;
    logic [QW-1:0]                 q_round_reg, q_round_next;
    logic [NTAPS-1:0]              tap_vld_reg;
    logic                          tap_vld_q_reg;

    logic                          m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]              m_value_reg, m_value_next;
    logic [mnfr_pkg::POS_W-1:0]    m_pos_reg, m_pos_next;
    logic                          m_pad_reg, m_pad_next;
    logic                          m_last_reg, m_last_next;

    // ------------------------------------------------------------------
    // Memories. The sample at row position x lives at address x modulo the
    // power-of-two window depth, so the last 2R+1 positions never collide.
    // ------------------------------------------------------------------
    logic                                 win_we;
    logic [WA-1:0]                        win_raddr;
    logic signed [mnfr_pkg::SAMPLE_W-1:0] win_q;
    logic                                 tap_we;
    logic [TW-1:0]                        tap_waddr;
    logic [TW-1:0]                        tap_raddr;
    logic signed [mnfr_pkg::SAMPLE_W-1:0] tap_q;
    logic signed [mnfr_pkg::SAMPLE_W-1:0] tap_eff;

    assign win_we    = in_accept && !s_tuser;
    assign tap_we    = in_accept && s_tuser && tap_idx_ok;
    assign tap_waddr = TW'(in_tap_idx);

    mnfr_ram #(
        .WIDTH (mnfr_pkg::SAMPLE_W),
        .DEPTH (WDEPTH)
    ) u_win_ram (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (WA'(row_cnt_reg)),
        .wdata (in_sample),
        .raddr (win_raddr),
        .rdata (win_q)
    );

    mnfr_ram #(
        .WIDTH (mnfr_pkg::SAMPLE_W),
        .DEPTH (NTAPS)
    ) u_tap_ram (
        .aclk  (aclk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (in_tap_val),
        .raddr (tap_raddr),
        .rdata (tap_q)
    );

    // A tap that was never loaded since reset reads as zero.
    assign tap_eff = tap_vld_q_reg ? tap_q : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_vld_reg <= '0;
        end else if (tap_we) begin
            tap_vld_reg[tap_waddr] <= 1'b1;
        end
        tap_vld_q_reg <= tap_vld_reg[tap_raddr];
    end

    // ------------------------------------------------------------------
    // Shared multiply-accumulate and divider.
    // ------------------------------------------------------------------
    mnfr_pkg::mac_ctl_t       mac_ctl;
    logic signed [ACC_W-1:0]  acc;
    logic signed [WS_W-1:0]   wsum;
    logic [ACC_W-1:0]         acc_mag;
    logic [WS_W-1:0]          wsum_mag;
    logic                     div_start;
    logic                     div_done;
    logic [NW-1:0]            div_quo;
    logic [WS_W-1:0]          div_rem;

    mnfr_mac #(
        .ACC_W (ACC_W),
        .WS_W  (WS_W)
    ) u_mac (
        .aclk   (aclk),
        .ctl    (mac_ctl),
        .tap    (tap_eff),
        .sample (win_q),
        .acc    (acc),
        .wsum   (wsum)
    );

    // The accumulator and tap sum hold still from the end of the tap walk
    // until the next clear, so their magnitudes feed the divider directly.
    assign acc_mag  = acc[ACC_W-1]  ? ACC_W'(-acc)  : ACC_W'(acc);
    assign wsum_mag = wsum[WS_W-1] ? WS_W'(-wsum) : WS_W'(wsum);

    mnfr_div #(
        .NW (NW),
        .DW (WS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({acc_mag, {mnfr_pkg::FRAC_W{1'b0}}}),
        .den     (wsum_mag),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    logic                          row_done;
    logic [mnfr_pkg::RADIUS_W-1:0] r_eff;
    logic                          p_ge_r;
    logic [XW-1:0]                 x_pos;
    logic                          x_in_row;
    logic [VAL_W-1:0]              pad_scaled;
    logic                          out_free;
    logic [QW-1:0]                 q_neg;

    // The last position a row can hold ends the row like row_end does.
    assign row_done = s_tlast || (row_cnt_reg >= CW'(MAX_ROW - 1));
    assign r_eff    = (32'(radius_reg) > MAX_RADIUS) ? mnfr_pkg::RADIUS_W'(MAX_RADIUS)
                                                     : radius_reg;
    assign p_ge_r   = (row_cnt_reg >= CW'(r_eff));

    // Neighbor position for tap k of center c; may fall before the row start.
    assign x_pos    = XW'(c_reg) - XW'(r_reg) + XW'(k_reg);
    assign x_in_row = !x_pos[XW-1] && (x_pos <= XW'(p_reg));

    assign pad_scaled = {{(VAL_W - mnfr_pkg::SAMPLE_W - mnfr_pkg::FRAC_W){pad_reg[15]}},
                         pad_reg, {mnfr_pkg::FRAC_W{1'b0}}};
    assign out_free   = !m_valid_reg || m_tready;
    assign q_neg      = QW'(0) - q_round_reg;
    assign s_tready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        p_next         = p_reg;
        c_next         = c_reg;
        c_end_next     = c_end_reg;
        r_next         = r_reg;
        end_next       = end_reg;
        k_next         = k_reg;
        rd_live_next   = 1'b0;
        res_value_next = res_value_reg;
        res_pad_next   = res_pad_reg;
        neg_next       = neg_reg;
        q_round_next   = q_round_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_value_next   = m_value_reg;
        m_pos_next     = m_pos_reg;
        m_pad_next     = m_pad_reg;
        m_last_next    = m_last_reg;
        win_raddr      = WA'(c_reg);
        tap_raddr      = TW'(k_reg);
        mac_ctl.clear  = 1'b0;
        mac_ctl.add    = rd_live_reg && (win_q > pad_reg);
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept && !s_tuser) begin
                    p_next   = row_cnt_reg;
                    r_next   = r_eff;
                    end_next = row_done;
                    if (row_done) begin
                        // Flush every center still owed for this row.
                        c_next       = p_ge_r ? row_cnt_reg - CW'(r_eff) : '0;
                        c_end_next   = row_cnt_reg;
                        row_cnt_next = '0;
                        state_next   = ST_CEN;
                    end else begin
                        row_cnt_next = row_cnt_reg + CW'(1);
                        if (p_ge_r) begin
                            c_next     = row_cnt_reg - CW'(r_eff);
                            c_end_next = row_cnt_reg - CW'(r_eff);
                            state_next = ST_CEN;
                        end
                    end
                end
            end
            ST_CEN: begin
                win_raddr  = WA'(c_reg);
                state_next = ST_CHK;
            end
            ST_CHK: begin
                // A center at or below padding yields the padding value.
                if (win_q <= pad_reg) begin
                    res_value_next = pad_scaled;
                    res_pad_next   = 1'b1;
                    state_next     = ST_EMIT;
                end else begin
                    mac_ctl.clear = 1'b1;
                    k_next        = '0;
                    state_next    = ST_MAC;
                end
            end
            ST_MAC: begin
                // Issue reads for tap k; the product is formed from the registered read data.
                win_raddr    = WA'(x_pos);
                tap_raddr    = TW'(k_reg);
                rd_live_next = x_in_row;
                if (k_reg == {r_reg, 1'b0}) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + 4'd1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                res_pad_next = 1'b0;
                if (!norm_reg) begin
                    res_value_next = {{(VAL_W - ACC_W){acc[ACC_W-1]}}, acc};
                    state_next     = ST_EMIT;
                end else if (wsum == '0) begin
                    res_value_next = pad_scaled;
                    res_pad_next   = 1'b1;
                    state_next     = ST_EMIT;
                end else begin
                    neg_next   = acc[ACC_W-1] ^ wsum[WS_W-1];
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                // Round half away from zero: bump when twice the remainder
                // reaches the divisor.
                q_round_next = {1'b0, div_quo}
                             + QW'({div_rem, 1'b0} >= {1'b0, wsum_mag});
                state_next   = ST_SAT;
            end
            ST_SAT: begin
                if (neg_reg) begin
                    res_value_next = (q_round_reg > Q_HALF) ? VAL_MIN : q_neg[VAL_W-1:0];
                end else begin
                    res_value_next = (q_round_reg >= Q_HALF) ? VAL_MAX
                                                             : q_round_reg[VAL_W-1:0];
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_pos_next   = mnfr_pkg::POS_W'(c_reg);
                    m_pad_next   = res_pad_reg;
                    m_last_next  = end_reg && (c_reg == p_reg);
                    if (c_reg == c_end_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        c_next     = c_reg + CW'(1);
                        state_next = ST_CEN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_cnt_reg <= '0;
            rd_live_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            rd_live_reg <= rd_live_next;
            m_valid_reg <= m_valid_next;
        end
        p_reg         <= p_next;
        c_reg         <= c_next;
        c_end_reg     <= c_end_next;
        r_reg         <= r_next;
        end_reg       <= end_next;
        k_reg         <= k_next;
        res_value_reg <= res_value_next;
        res_pad_reg   <= res_pad_next;
        neg_reg       <= neg_next;
        q_round_reg   <= q_round_next;
        m_value_reg   <= m_value_next;
        m_pos_reg     <= m_pos_next;
        m_pad_reg     <= m_pad_next;
        m_last_reg    <= m_last_next;
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{mnfr_pkg::M_PAD_W{1'b0}}, m_pos_reg, m_value_reg};
    assign m_tuser  = m_pad_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- sv/mnfr_checker.sv -----
// ----------------------------------------------------------------------------
// mnfr_checker
// Port-level checks of the row filter, bound to the top level.
// ----------------------------------------------------------------------------
module mnfr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mnfr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A tap load causes no work, so the block stays ready.
    a_tap_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> s_tready)
        else $error("not ready after tap load");

    // The end of a row always causes at least one result, so the block busies.
    a_row_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && s_tlast |=> !s_tready)
        else $error("row end accepted without work");

    // A padding result is the padding value scaled by 2^14.
    a_pad_scaled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[mnfr_pkg::FRAC_W-1:0] == '0)
        else $error("padding result not scaled");

endmodule

bind masked_normalized_fir_row_core mnfr_checker u_mnfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/mnfr_row_check.sv -----
// ----------------------------------------------------------------------------
// mnfr_row_check
// Watches the configuration port and both item channels of the masked row
// filter, computes the results every accepted item should cause and compares
// each returned result, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module mnfr_row_check (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mnfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mnfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // s_tdata from bit 0 up: sample, tap_index, tap_value, zero fill.
    input  logic [mnfr_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: action.
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0 up: value, position, zero fill.
    input  logic [mnfr_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: is_padding.
    input  logic                              m_tuser,
    input  logic                              m_tlast,
    output int unsigned                       mismatches,
    output int unsigned                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAPS   = 15;
    localparam int ROW_MAX = 4096;
    localparam longint unsigned MAG_NEG = 64'd549755813888;
    localparam longint unsigned MAG_POS = 64'd549755813887;

    typedef struct packed {
        logic signed [mnfr_pkg::VAL_W-1:0] value;
        logic [mnfr_pkg::POS_W-1:0]        position;
        logic                              pad;
        logic                              last;
    } row_result_t;

    // Filter state as the block should hold it.
    logic signed [mnfr_pkg::SAMPLE_W-1:0] taps [NTAPS];
    logic signed [mnfr_pkg::SAMPLE_W-1:0] win  [NTAPS];   // newest sample first
    int                                   row_pos;
    logic signed [mnfr_pkg::SAMPLE_W-1:0] padding;
    logic                                 norm;
    logic [mnfr_pkg::RADIUS_W-1:0]        radius;

    row_result_t due_results [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 60) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Rounded division, ties away from zero, saturated to the value width.
    function automatic logic [mnfr_pkg::VAL_W-1:0] round_div(input longint num,
                                                             input longint den);
        bit                neg;
        longint unsigned   un;
        longint unsigned   ud;
        longint unsigned   q;
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        q   = (2 * un + ud) / (2 * ud);
        if (neg) begin
            if (q > MAG_NEG) return 40'h80_0000_0000;
            return mnfr_pkg::VAL_W'(-q);
        end
        if (q > MAG_POS) return 40'h7F_FFFF_FFFF;
        return mnfr_pkg::VAL_W'(q);
    endfunction

    // Result for center c while the newest sample sits at row position p.
    function automatic row_result_t filter_at(input int c, input int p, input int r,
                                              input bit last_c);
        row_result_t                          res;
        longint                               acc;
        longint                               wsum;
        logic signed [mnfr_pkg::SAMPLE_W-1:0] s;
        bit                                   pad;
        int                                   x;
        acc  = 0;
        wsum = 0;
        pad  = 0;
        if (win[p - c] <= padding) begin
            pad = 1;
        end else begin
            for (int k = 0; k <= 2 * r; k++) begin
                x = c - r + k;
                if (x >= 0 && x <= p && p - x < NTAPS) begin
                    s = win[p - x];
                    if (s > padding) begin
                        acc  += longint'(taps[k]) * longint'(s);
                        wsum += longint'(taps[k]);
                    end
                end
            end
        end
        if (!pad && norm && wsum == 0) pad = 1;
        if (pad) begin
            res.value = mnfr_pkg::VAL_W'(longint'(padding) * 16384);
        end else if (norm) begin
            res.value = round_div(acc * 16384, wsum);
        end else begin
            res.value = mnfr_pkg::VAL_W'(acc);
        end
        res.position = mnfr_pkg::POS_W'(c);
        res.pad      = pad;
        res.last     = last_c;
        return res;
    endfunction

    task automatic take_item(input logic action,
                             input logic [mnfr_pkg::S_TDATA_W-1:0] data,
                             input logic row_end);
        logic [mnfr_pkg::TAP_IDX_W-1:0] idx;
        int                             p;
        int                             r;
        int                             first;
        bit                             ends;
        if (action) begin
            idx = data[19:16];
            if (int'(idx) < NTAPS) taps[idx] = data[35:20];
        end else begin
            for (int i = NTAPS - 1; i > 0; i--) win[i] = win[i - 1];
            win[0] = data[15:0];
            r    = int'(radius);
            p    = row_pos;
            ends = row_end || p >= ROW_MAX - 1;
            if (!ends) begin
                if (p >= r) due_results.push_back(filter_at(p - r, p, r, 1'b0));
                row_pos++;
            end else begin
                first = (p >= r) ? p - r : 0;
                for (int c = first; c <= p; c++)
                    due_results.push_back(filter_at(c, p, r, c == p));
                row_pos = 0;
            end
        end
    endtask

    task automatic check_result(input logic [mnfr_pkg::M_TDATA_W-1:0] data,
                                input logic pad, input logic last);
        row_result_t want;
        if (due_results.size() == 0) begin
            report($sformatf("result at position %0d with none due", data[51:40]));
        end else begin
            want = due_results.pop_front();
            if (data[39:0] !== want.value)
                report($sformatf("position %0d value %h, want %h",
                                 want.position, data[39:0], want.value));
            if (data[51:40] !== want.position)
                report($sformatf("position %0d, want %0d", data[51:40], want.position));
            if (data[55:52] !== '0)
                report($sformatf("position %0d fill bits %b", want.position, data[55:52]));
            if (pad !== want.pad)
                report($sformatf("position %0d is_padding %b, want %b",
                                 want.position, pad, want.pad));
            if (last !== want.last)
                report($sformatf("position %0d last_of_row %b, want %b",
                                 want.position, last, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NTAPS; i++) begin
                taps[i] = '0;
                win[i]  = '0;
            end
            row_pos = 0;
            padding = '0;
            norm    = 1'b1;
            radius  = mnfr_pkg::RADIUS_W'(1);
            due_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mnfr_pkg::CFG_PADDING:   padding = cfg_wdata;
                    mnfr_pkg::CFG_NORMALIZE: norm    = cfg_wdata[0];
                    mnfr_pkg::CFG_RADIUS:    radius  = cfg_wdata[mnfr_pkg::RADIUS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) take_item(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready) check_result(m_tdata, m_tuser, m_tlast);
        end
        outstanding = due_results.size();
    end

endmodule

// ----- tb/tb_masked_normalized_fir_row_core.sv -----
// ----------------------------------------------------------------------------
// tb_masked_normalized_fir_row_core
// Drives tap loads, row samples and register writes into the masked row
// filter; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_masked_normalized_fir_row_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Meaning of s_tuser.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TAP    = 1'b1;

    // The pause outlasts the longest a result can take in normalize mode,
    // so it covers anything the block may still be working on.
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_ITEMS  = 85;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [mnfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mnfr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [mnfr_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [mnfr_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    int unsigned mismatches;
    int unsigned outstanding;

    // Stimulus bookkeeping: the padding value now in force steers the sample
    // values toward the exclusion boundary; burst_left counts the items left
    // in the current sender burst.
    logic signed [15:0] pad_now;
    int                 burst_left;
    int                 rand_items;
    int                 rad;
    int                 rows;
    int                 len;
    int                 tap_idx;

    always #2 aclk = ~aclk;

    masked_normalized_fir_row_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    mnfr_row_check u_row_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // The receiver switches between modes of random length: always ready,
    // a coin toss each cycle, mostly stalled, and a fixed on/off rhythm.
    // The always-ready mode gives stretches where the output never stalls.
    int          rx_mode;
    int          rx_left = 0;
    int unsigned rx_tick = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= rx_tick[2];
        endcase
    end

    // Hands one item to the block. Items go out in bursts of random length;
    // between bursts the valid drops for a random number of cycles, and a
    // gap of zero lets two bursts run together without any idle cycle.
    // The fields that the action does not use carry random bits.
    task automatic send(input logic action, input logic [15:0] smp,
                        input logic [3:0] idx, input logic [15:0] tap,
                        input logic row_end);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tdata  <= {4'b0000, tap, idx, smp};
        s_tuser  <= action;
        s_tlast  <= row_end;
        s_tvalid <= 1'b1;
        burst_left--;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_sample(input logic [15:0] smp, input logic row_end);
        send(ACT_SAMPLE, smp, 4'($urandom), 16'($urandom), row_end);
    endtask

    // A tap load ignores the sample and row-end fields, so they get noise.
    task automatic send_tap(input logic [3:0] idx, input logic [15:0] tap);
        send(ACT_TAP, 16'($urandom), idx, tap, 1'($urandom));
    endtask

    // Registers only change once the block has drained and gone quiet.
    task automatic settle();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [mnfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == mnfr_pkg::CFG_PADDING) pad_now = data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Samples cluster around the padding value: exactly on it, just below
    // it, a little above it, or anywhere in the full range.
    function automatic logic [15:0] pick_sample();
        int v;
        case ($urandom_range(0, 7))
            0:       v = $signed(16'($urandom));
            1:       v = pad_now;
            2:       v = int'(pad_now) - int'($urandom_range(1, 500));
            default: v = int'(pad_now) + int'($urandom_range(1, 3000));
        endcase
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return 16'(v);
    endfunction

    // Mostly positive weights up to 0.5, some negative, some zero and some
    // from the full range, which can drive the quotient into saturation.
    function automatic logic [15:0] pick_tap();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom);
            1:       return 16'h0000;
            2:       return 16'(-int'($urandom_range(0, 8192)));
            default: return 16'($urandom_range(0, 8192));
        endcase
    endfunction

    initial begin
        pad_now    = '0;
        burst_left = 0;
        rand_items = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, starting from the reset settings: padding 0,
        // normalize on, radius 1. Taps at the extremes of the Q2.14 range,
        // plus a load to an index past the kernel, which must be dropped.
        send_tap(4'd0, 16'd16384);
        send_tap(4'd1, 16'h7FFF);
        send_tap(4'd2, 16'h8000);
        send_tap(4'd15, 16'h1234);
        // A row with the sample extremes: the center below padding and the
        // center equal to padding both give a padding result, and the first
        // and last results drop the neighbors that lie outside the row.
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'd5, 1'b1);
        // A row shorter than the kernel: its only center comes out at row end.
        send_sample(16'd77, 1'b1);
        // The taps sum to zero, so normalize mode gives padding for every center but the first.
        send_tap(4'd0, 16'd16384);
        send_tap(4'd1, 16'hC000);
        send_tap(4'd2, 16'h0000);
        send_sample(16'd100, 1'b0);
        send_sample(16'd200, 1'b0);
        send_sample(16'd300, 1'b1);

        // Raw sums at the widest radius with the lowest padding value, where
        // only the most negative sample is excluded; the row is short.
        settle();
        write_reg(mnfr_pkg::CFG_NORMALIZE, 16'd0);
        write_reg(mnfr_pkg::CFG_RADIUS, 16'd7);
        write_reg(mnfr_pkg::CFG_PADDING, 16'h8000);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 1'b1);

        // The radius grows inside a row, so the center at position zero is
        // produced a second time.
        settle();
        write_reg(mnfr_pkg::CFG_RADIUS, 16'd0);
        send_sample(16'd1000, 1'b0);
        send_sample(16'd2000, 1'b0);
        settle();
        write_reg(mnfr_pkg::CFG_RADIUS, 16'd2);
        send_sample(16'd3000, 1'b0);
        send_sample(16'd4000, 1'b1);

        // The highest padding value excludes every sample.
        settle();
        write_reg(mnfr_pkg::CFG_PADDING, 16'h7FFF);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h1234, 1'b1);

        // Random part: each phase picks settings, loads a kernel for the
        // chosen radius and streams a few rows of random length. Now and
        // then a tap load lands inside a row, or the radius changes in the
        // middle of a row.
        while (rand_items < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 9))
                0:       write_reg(mnfr_pkg::CFG_PADDING, 16'h8000);
                1:       write_reg(mnfr_pkg::CFG_PADDING, 16'h7FFF);
                2:       write_reg(mnfr_pkg::CFG_PADDING, 16'($urandom));
                default: write_reg(mnfr_pkg::CFG_PADDING,
                                   16'(int'($urandom_range(0, 400)) - 200));
            endcase
            write_reg(mnfr_pkg::CFG_NORMALIZE, 16'($urandom_range(0, 1)));
            rad = $urandom_range(0, 7);
            write_reg(mnfr_pkg::CFG_RADIUS, 16'(rad));
            for (int k = 0; k <= 2 * rad; k++) begin
                send_tap(4'(k), pick_tap());
                rand_items++;
            end
            rows = $urandom_range(1, 3);
            repeat (rows) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        tap_idx = $urandom_range(0, 15);
                        send_tap(4'(tap_idx), pick_tap());
                        if (tap_idx < 15) rand_items++;
                    end
                    if (i > 0 && $urandom_range(0, 24) == 0) begin
                        settle();
                        write_reg(mnfr_pkg::CFG_RADIUS, 16'($urandom_range(0, 7)));
                    end
                    send_sample(pick_sample(), i == len - 1);
                    rand_items++;
                end
            end
        end

        // Drain: wait for every due result, then give the block time to
        // show any result it should not produce.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_masked_normalized_fir_row_core: clean");
        end else begin
            $display("tb_masked_normalized_fir_row_core: errors");
        end
        $finish;
    end

    // Watchdog: ends a run that hangs.
    initial begin
        #3_000_000;
        $display("tb_masked_normalized_fir_row_core: errors");
        $finish;
    end

endmodule
